// ===== design/tfe_pkg.sv =====
package tfe_pkg;

  localparam int MAX_CHANNELS = 32;
  localparam int MAX_BINS     = 1024;

  localparam int BIN_W   = $clog2(MAX_BINS);
  localparam int POS_W   = BIN_W + 1;
  localparam int CH_W    = $clog2(MAX_CHANNELS);
  localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
  localparam int FREQ_W  = 20;
  localparam int NUM_W   = FREQ_W + 2;
  localparam int E_W     = 48;
  localparam int FRAC_W  = 16;
  localparam int Q_W     = FRAC_W + 1;
  localparam int VAL_W   = 32;
  localparam int PROD_W  = VAL_W + Q_W;
  localparam int DIVN_W  = (BIN_W + FRAC_W > NUM_W) ? BIN_W + FRAC_W : NUM_W;
  localparam int DIVD_W  = FREQ_W + 1;
  localparam int DCNT_W  = $clog2(DIVN_W + 1);
  localparam int REG_IDX_W = 2;

  localparam logic [Q_W-1:0] Q_ONE = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [E_W-1:0] E_MAX = {E_W{1'b1}};

  localparam logic [5:0]        RST_CHANNEL_COUNT = 6'd24;
  localparam logic [FREQ_W-1:0] RST_BIN_WIDTH     = 20'd1000;
  localparam logic [FREQ_W-1:0] RST_LOW_FREQ      = 20'd3000;
  localparam logic [FREQ_W-1:0] RST_HIGH_FREQ     = 20'd128000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CHANNEL_COUNT,
    REG_BIN_WIDTH,
    REG_LOW_FREQ,
    REG_HIGH_FREQ
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_CH_RD0,
    ST_CH_RD1,
    ST_CH_WT,
    ST_MUL,
    ST_ACC,
    ST_CH_NEXT,
    ST_BIN_END,
    ST_EMIT_T,
    ST_EMIT_C,
    ST_EMIT_W
  } state_t;

  typedef enum logic [2:0] {
    DIV_LO,
    DIV_UP,
    DIV_LEFT,
    DIV_RIGHT,
    DIV_WT
  } div_op_t;

  function automatic logic [BIN_W-1:0] clamp_bin(input logic [DIVN_W-1:0] v);
    if (v > DIVN_W'(MAX_BINS - 1)) begin
      clamp_bin = BIN_W'(MAX_BINS - 1);
    end else begin
      clamp_bin = v[BIN_W-1:0];
    end
  endfunction

  function automatic logic [E_W-1:0] sat_add(input logic [E_W-1:0] a, input logic [E_W-1:0] b);
    logic [E_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[E_W] ? E_MAX : s[E_W-1:0];
  endfunction

endpackage

// ===== design/trapezoid_filterbank_energy_unit.sv =====
// channel  | direction | handshake                 | payload
// item     | in        | item_valid / item_stall   | opcode channel_index centre_freq
//          |           |                           | plateau_width bin_value last_bin
// result   | out       | result_valid / result_stall | energy channel_number last
// config   | in        | cfg_write                 | cfg_index cfg_data
//
// one shared restoring divider (one quotient bit per cycle, DIVN_W = 26 quotient bits) does
// all divisions
// a channel load takes 2 divisions
// a bin takes 2 divisions plus, per channel, one more division on a ramp
// a frame end emits the total, then one result per channel, each held while result_stall is high; item_stall stays high
// rst is synchronous; it clears all edges and accumulators
module trapezoid_filterbank_energy_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        opcode,
  input  logic [5:0]                  channel_index,
  input  logic [tfe_pkg::FREQ_W-1:0]  centre_freq,
  input  logic [tfe_pkg::FREQ_W-1:0]  plateau_width,
  input  logic [tfe_pkg::VAL_W-1:0]   bin_value,
  input  logic                        last_bin,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [tfe_pkg::E_W-1:0]     energy,
  output logic [5:0]                  channel_number,
  output logic                        last,
  input  logic                        cfg_write,
  input  logic [tfe_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [tfe_pkg::FREQ_W-1:0]  cfg_data
);

  tfe_pkg::state_t  state, state_next;
  tfe_pkg::div_op_t div_op;

  logic [5:0]                 channel_count;
  logic [tfe_pkg::FREQ_W-1:0] bin_width, low_freq_limit, high_freq_limit;
  logic [tfe_pkg::FREQ_W-1:0] w_eff;
  logic [tfe_pkg::DIVD_W-1:0] two_w;
  logic [tfe_pkg::CNT_W-1:0]  n_use;

  // shared divider
  logic [tfe_pkg::DIVD_W-1:0] div_rem, div_den;
  logic [tfe_pkg::DIVN_W-1:0] div_quo;
  logic [tfe_pkg::DCNT_W-1:0] div_cnt;
  logic [tfe_pkg::DIVD_W:0]   div_sh, div_diff;
  logic                       div_ge, div_fin;

  // latched word
  logic [tfe_pkg::CH_W-1:0]   ld_idx;
  logic [tfe_pkg::NUM_W-1:0]  up_num;
  logic                       lo_neg;
  logic [tfe_pkg::BIN_W-1:0]  lo_res;
  logic [tfe_pkg::VAL_W-1:0]  val;
  logic                       last_reg;
  logic [tfe_pkg::NUM_W-1:0]  lo_sum, lo_num, up_sum;

  // bin scan
  logic [tfe_pkg::POS_W-1:0]  pos;
  logic [tfe_pkg::CNT_W-1:0]  ch, ch_inc;
  logic [tfe_pkg::BIN_W-1:0]  left, right, p_reg, cur_lo, cur_up;
  logic [tfe_pkg::BIN_W-1:0]  k, q, nxt_lo;
  logic                       plateau, rising, falling;
  logic [tfe_pkg::Q_W-1:0]    wt;
  logic [tfe_pkg::PROD_W-1:0] prod;
  logic [tfe_pkg::E_W-1:0]    total;

  // edge and energy stores
  logic [2*tfe_pkg::BIN_W-1:0] edge_mem [tfe_pkg::MAX_CHANNELS];
  logic [tfe_pkg::MAX_CHANNELS-1:0] edge_vld;
  logic [2*tfe_pkg::BIN_W-1:0] edge_rd;
  logic                        edge_ok, edge_we;
  logic [tfe_pkg::CH_W-1:0]    edge_ra;
  logic [tfe_pkg::E_W-1:0]     en_mem [tfe_pkg::MAX_CHANNELS];
  logic [tfe_pkg::MAX_CHANNELS-1:0] en_vld;
  logic [tfe_pkg::E_W-1:0]     en_rd, en_val, en_new;
  logic                        en_ok, en_we;

  logic acc_item, res_take;

  assign w_eff   = (bin_width == '0) ? tfe_pkg::FREQ_W'(1) : bin_width;
  assign two_w   = {w_eff, 1'b0};
  assign n_use   = (channel_count > 6'(tfe_pkg::MAX_CHANNELS))
                 ? tfe_pkg::CNT_W'(tfe_pkg::MAX_CHANNELS) : tfe_pkg::CNT_W'(channel_count);

  assign div_sh   = {div_rem, div_quo[tfe_pkg::DIVN_W-1]};
  assign div_diff = div_sh - {1'b0, div_den};
  assign div_ge   = div_sh >= {1'b0, div_den};
  assign div_fin  = (state == tfe_pkg::ST_DIV) && (div_cnt == '0);

  assign lo_sum = tfe_pkg::NUM_W'({centre_freq, 1'b0}) + tfe_pkg::NUM_W'(w_eff);
  assign lo_num = lo_sum - tfe_pkg::NUM_W'(plateau_width);
  assign up_sum = tfe_pkg::NUM_W'({centre_freq, 1'b0}) + tfe_pkg::NUM_W'(plateau_width);

  assign ch_inc  = ch + 1'b1;
  assign edge_ra = (state == tfe_pkg::ST_CH_RD1) ? ch_inc[tfe_pkg::CH_W-1:0]
                                                 : ch[tfe_pkg::CH_W-1:0];
  assign en_val  = en_ok ? en_rd : '0;
  assign en_new  = tfe_pkg::sat_add(en_val, tfe_pkg::E_W'(prod[tfe_pkg::PROD_W-1:tfe_pkg::FRAC_W]));

  assign k       = pos[tfe_pkg::BIN_W-1:0];
  assign nxt_lo  = edge_ok ? edge_rd[2*tfe_pkg::BIN_W-1:tfe_pkg::BIN_W] : '0;
  assign q       = (ch_inc == n_use) ? right : nxt_lo;
  assign plateau = (k >= cur_lo) && (k <= cur_up);
  assign rising  = (cur_lo > p_reg) && (k > p_reg) && (k < cur_lo);
  assign falling = (q > cur_up) && (k > cur_up) && (k < q);

  assign acc_item     = item_valid && !item_stall;
  assign result_valid = (state == tfe_pkg::ST_EMIT_W);
  assign res_take     = result_valid && !result_stall;
  assign edge_we      = div_fin && (div_op == tfe_pkg::DIV_UP);
  assign en_we        = (state == tfe_pkg::ST_ACC);

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    unique case (state)
      tfe_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (!opcode) begin
            if (channel_index < 6'(tfe_pkg::MAX_CHANNELS)) state_next = tfe_pkg::ST_DIV;
          end else if (pos < tfe_pkg::POS_W'(tfe_pkg::MAX_BINS)) begin
            state_next = tfe_pkg::ST_DIV;
          end else if (last_bin) begin
            state_next = tfe_pkg::ST_EMIT_T;
          end
        end
      end
      tfe_pkg::ST_DIV: begin
        if (div_cnt == '0) begin
          unique case (div_op)
            tfe_pkg::DIV_LO, tfe_pkg::DIV_LEFT: state_next = tfe_pkg::ST_DIV;
            tfe_pkg::DIV_UP:    state_next = tfe_pkg::ST_IDLE;
            tfe_pkg::DIV_RIGHT: state_next = (n_use == '0) ? tfe_pkg::ST_BIN_END
                                                           : tfe_pkg::ST_CH_RD0;
            tfe_pkg::DIV_WT:    state_next = tfe_pkg::ST_MUL;
            default:            state_next = tfe_pkg::ST_IDLE;
          endcase
        end
      end
      tfe_pkg::ST_CH_RD0:  state_next = tfe_pkg::ST_CH_RD1;
      tfe_pkg::ST_CH_RD1:  state_next = tfe_pkg::ST_CH_WT;
      tfe_pkg::ST_CH_WT:   state_next = (!plateau && (rising || falling)) ? tfe_pkg::ST_DIV
                                                                          : tfe_pkg::ST_MUL;
      tfe_pkg::ST_MUL:     state_next = tfe_pkg::ST_ACC;
      tfe_pkg::ST_ACC:     state_next = tfe_pkg::ST_CH_NEXT;
      tfe_pkg::ST_CH_NEXT: state_next = (ch_inc == n_use) ? tfe_pkg::ST_BIN_END
                                                          : tfe_pkg::ST_CH_RD0;
      tfe_pkg::ST_BIN_END: state_next = last_reg ? tfe_pkg::ST_EMIT_T : tfe_pkg::ST_IDLE;
      tfe_pkg::ST_EMIT_T:  state_next = tfe_pkg::ST_EMIT_W;
      tfe_pkg::ST_EMIT_C:  state_next = tfe_pkg::ST_EMIT_W;
      tfe_pkg::ST_EMIT_W: begin
        if (!result_stall) state_next = last ? tfe_pkg::ST_IDLE : tfe_pkg::ST_EMIT_C;
      end
      default: state_next = tfe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count   <= tfe_pkg::RST_CHANNEL_COUNT;
      bin_width       <= tfe_pkg::RST_BIN_WIDTH;
      low_freq_limit  <= tfe_pkg::RST_LOW_FREQ;
      high_freq_limit <= tfe_pkg::RST_HIGH_FREQ;
    end else if (cfg_write) begin
      unique case (tfe_pkg::reg_idx_t'(cfg_index))
        tfe_pkg::REG_CHANNEL_COUNT: channel_count   <= cfg_data[5:0];
        tfe_pkg::REG_BIN_WIDTH:     bin_width       <= cfg_data;
        tfe_pkg::REG_LOW_FREQ:      low_freq_limit  <= cfg_data;
        tfe_pkg::REG_HIGH_FREQ:     high_freq_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt  <= '0;
      div_op   <= tfe_pkg::DIV_LO;
      pos      <= '0;
      ch       <= '0;
      total    <= '0;
      edge_vld <= '0;
      en_vld   <= '0;
    end else begin
      unique case (state)
        tfe_pkg::ST_IDLE: begin
          if (acc_item) begin
            ld_idx   <= channel_index[tfe_pkg::CH_W-1:0];
            up_num   <= up_sum;
            lo_neg   <= lo_sum < tfe_pkg::NUM_W'(plateau_width);
            val      <= bin_value;
            last_reg <= last_bin;
            ch       <= '0;
            div_rem  <= '0;
            div_cnt  <= tfe_pkg::DCNT_W'(tfe_pkg::DIVN_W);
            div_den  <= two_w;
            if (!opcode) begin
              div_op  <= tfe_pkg::DIV_LO;
              div_quo <= tfe_pkg::DIVN_W'(lo_num);
            end else begin
              div_op  <= tfe_pkg::DIV_LEFT;
              div_quo <= tfe_pkg::DIVN_W'({low_freq_limit, 1'b0}) + tfe_pkg::DIVN_W'(w_eff);
            end
          end
        end
        tfe_pkg::ST_DIV: begin
          if (div_cnt != '0) begin
            div_rem <= div_ge ? div_diff[tfe_pkg::DIVD_W-1:0] : div_sh[tfe_pkg::DIVD_W-1:0];
            div_quo <= {div_quo[tfe_pkg::DIVN_W-2:0], div_ge};
            div_cnt <= div_cnt - 1'b1;
          end else begin
            unique case (div_op)
              tfe_pkg::DIV_LO: begin
                lo_res  <= lo_neg ? '0 : tfe_pkg::clamp_bin(div_quo);
                div_op  <= tfe_pkg::DIV_UP;
                div_quo <= tfe_pkg::DIVN_W'(up_num);
                div_den <= two_w;
                div_rem <= '0;
                div_cnt <= tfe_pkg::DCNT_W'(tfe_pkg::DIVN_W);
              end
              tfe_pkg::DIV_UP: begin
                edge_vld[ld_idx] <= 1'b1;
              end
              tfe_pkg::DIV_LEFT: begin
                left    <= (div_quo == '0) ? '0 : tfe_pkg::clamp_bin(div_quo - 1'b1);
                div_op  <= tfe_pkg::DIV_RIGHT;
                div_quo <= tfe_pkg::DIVN_W'(high_freq_limit);
                div_den <= tfe_pkg::DIVD_W'(w_eff);
                div_rem <= '0;
                div_cnt <= tfe_pkg::DCNT_W'(tfe_pkg::DIVN_W);
              end
              tfe_pkg::DIV_RIGHT: begin
                right <= tfe_pkg::clamp_bin(div_quo);
                p_reg <= left;
                ch    <= '0;
              end
              tfe_pkg::DIV_WT: begin
                wt <= div_quo[tfe_pkg::Q_W-1:0];
              end
              default: ;
            endcase
          end
        end
        tfe_pkg::ST_CH_RD1: begin
          cur_lo <= edge_ok ? edge_rd[2*tfe_pkg::BIN_W-1:tfe_pkg::BIN_W] : '0;
          cur_up <= edge_ok ? edge_rd[tfe_pkg::BIN_W-1:0] : '0;
        end
        tfe_pkg::ST_CH_WT: begin
          wt      <= plateau ? tfe_pkg::Q_ONE : '0;
          div_op  <= tfe_pkg::DIV_WT;
          div_rem <= '0;
          div_cnt <= tfe_pkg::DCNT_W'(tfe_pkg::DIVN_W);
          if (rising) begin
            div_quo <= tfe_pkg::DIVN_W'({k - p_reg, {tfe_pkg::FRAC_W{1'b0}}});
            div_den <= tfe_pkg::DIVD_W'(cur_lo - p_reg);
          end else begin
            div_quo <= tfe_pkg::DIVN_W'({q - k, {tfe_pkg::FRAC_W{1'b0}}});
            div_den <= tfe_pkg::DIVD_W'(q - cur_up);
          end
        end
        tfe_pkg::ST_MUL: begin
          prod <= tfe_pkg::PROD_W'(val) * tfe_pkg::PROD_W'(wt);
        end
        tfe_pkg::ST_ACC: begin
          en_vld[ch[tfe_pkg::CH_W-1:0]] <= 1'b1;
          total <= tfe_pkg::sat_add(total,
                     tfe_pkg::E_W'(prod[tfe_pkg::PROD_W-1:tfe_pkg::FRAC_W]));
        end
        tfe_pkg::ST_CH_NEXT: begin
          p_reg <= cur_up;
          ch    <= ch_inc;
        end
        tfe_pkg::ST_BIN_END: begin
          pos <= pos + 1'b1;
          ch  <= '0;
        end
        tfe_pkg::ST_EMIT_T: begin
          energy         <= total;
          channel_number <= '0;
          last           <= (n_use == '0);
        end
        tfe_pkg::ST_EMIT_C: begin
          energy         <= en_val;
          channel_number <= 6'(ch_inc);
          last           <= (ch_inc == n_use);
          ch             <= ch_inc;
        end
        tfe_pkg::ST_EMIT_W: begin
          if (res_take && last) begin
            total  <= '0;
            pos    <= '0;
            en_vld <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // edge store, one word per channel: lower bin then upper bin
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[ld_idx] <= {lo_res, tfe_pkg::clamp_bin(div_quo)};
    end
    edge_rd <= edge_mem[edge_ra];
    edge_ok <= edge_vld[edge_ra];
  end

  // channel energy store
  always_ff @(posedge clk) begin
    if (en_we) begin
      en_mem[ch[tfe_pkg::CH_W-1:0]] <= en_new;
    end
    en_rd <= en_mem[ch[tfe_pkg::CH_W-1:0]];
    en_ok <= en_vld[ch[tfe_pkg::CH_W-1:0]];
  end

`ifndef SYNTH
  a_div_cnt_range: assert property (@(posedge clk) disable iff (rst)
    div_cnt <= tfe_pkg::DCNT_W'(tfe_pkg::DIVN_W))
    else $error("divider count out of range");

  a_no_take_while_emit: assert property (@(posedge clk) disable iff (rst)
    !item_stall |-> !result_valid)
    else $error("word taken during result emission");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (res_take && last) |=> (total == '0) && (pos == '0) && (en_vld == '0))
    else $error("accumulators not cleared after frame");

  a_channel_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == tfe_pkg::ST_CH_WT) |-> (ch < n_use))
    else $error("channel scan past channel count");

  a_result_number: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (channel_number <= 6'(n_use)))
    else $error("result channel number past channel count");
`endif

endmodule
